// ===== rtl/ptts_pkg.sv =====
// Shared types and constants for the periodic task tick scheduler.
// Used by ptts_cell and periodic_task_tick_scheduler; no dependencies.
package ptts_pkg;

  localparam int PTTS_MAX_TASKS = 8;
  // Slot index width: 5 bits, room for up to 32 slot indices.
  localparam int PTTS_IDX_W     = 5;

  localparam logic [1:0] POL_RM  = 2'd0;
  localparam logic [1:0] POL_DM  = 2'd1;
  localparam logic [1:0] POL_EDF = 2'd2;

  localparam logic CFG_POLICY = 1'b0;
  localparam logic CFG_ACTIVE = 1'b1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Running best candidate handed from cell to cell.
  typedef struct packed {
    logic                  found;
    logic [31:0]           key;
    logic [PTTS_IDX_W-1:0] idx;
  } search_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic                  load;
    logic [2:0]            slot;
    logic [15:0]           period;
    logic [15:0]           run_time;
    logic [15:0]           rel_deadline;
    logic                  update;
    logic [31:0]           now;
    logic                  dec;
    logic [PTTS_IDX_W-1:0] dec_idx;
    logic [1:0]            policy;
    logic [3:0]            active;
  } cell_ctrl_t;

endpackage

// ===== rtl/ptts_cell.sv =====
// One task slot of the scheduler chain: parameters, phase, work and deadline,
// plus one registered stage of the minimum-key search. Depends on ptts_pkg.
module ptts_cell #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ptts_pkg::cell_ctrl_t ctrl,
  input  ptts_pkg::search_t   best_in,
  output ptts_pkg::search_t   best_out
);
  import ptts_pkg::*;

  localparam logic [PTTS_IDX_W-1:0] MY_IDX = PTTS_IDX_W'(IDX);

  logic [15:0] period_r, period_nxt;
  logic [15:0] run_r, run_nxt;
  logic [15:0] dl_r, dl_nxt;
  logic [15:0] work_r, work_nxt;
  logic [31:0] abs_r, abs_nxt;
  logic [15:0] phase_r, phase_nxt;
  search_t     best_r, best_nxt;

  logic [16:0] phase_inc;
  logic [31:0] key;
  logic        eligible;
  logic        slot_hit;

  assign phase_inc = {1'b0, phase_r} + 17'd1;
  assign slot_hit  = ctrl.load && ({2'b00, ctrl.slot} == MY_IDX);
  assign eligible  = ({1'b0, MY_IDX} < {2'b00, ctrl.active}) && (work_r != 16'd0);

  always_comb begin
    case (ctrl.policy)
      POL_DM:  key = {16'd0, dl_r};
      POL_EDF: key = abs_r;
      default: key = {16'd0, period_r};
    endcase
  end

  always_comb begin
    period_nxt = period_r;
    run_nxt    = run_r;
    dl_nxt     = dl_r;
    work_nxt   = work_r;
    abs_nxt    = abs_r;
    phase_nxt  = phase_r;
    if (ctrl.load) begin
      if (slot_hit) begin
        period_nxt = (ctrl.period == 16'd0) ? 16'd1 : ctrl.period;
        run_nxt    = ctrl.run_time;
        dl_nxt     = ctrl.rel_deadline;
      end
      // restart from time zero
      work_nxt  = run_nxt;
      abs_nxt   = {16'd0, dl_nxt};
      phase_nxt = 16'd0;
    end else if (ctrl.update) begin
      if ((ctrl.policy == POL_EDF) && (ctrl.now >= abs_r)) begin
        abs_nxt = abs_r + {16'd0, dl_r};
      end
      if (phase_r == 16'd0) begin
        work_nxt = run_r;
      end
      phase_nxt = (phase_inc >= {1'b0, period_r}) ? 16'd0 : phase_inc[15:0];
    end else if (ctrl.dec && (ctrl.dec_idx == MY_IDX)) begin
      work_nxt = work_r - 16'd1;
    end
  end

  // Take over the candidate when this slot beats it; ties keep the lower slot.
  always_comb begin
    best_nxt = best_in;
    if (eligible && (!best_in.found || (key < best_in.key))) begin
      best_nxt.found = 1'b1;
      best_nxt.key   = key;
      best_nxt.idx   = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= '0;
      run_r    <= '0;
      dl_r     <= '0;
      work_r   <= '0;
      abs_r    <= '0;
      phase_r  <= '0;
      best_r   <= '0;
    end else begin
      period_r <= period_nxt;
      run_r    <= run_nxt;
      dl_r     <= dl_nxt;
      work_r   <= work_nxt;
      abs_r    <= abs_nxt;
      phase_r  <= phase_nxt;
      best_r   <= best_nxt;
    end
  end

  assign best_out = best_r;

endmodule

// ===== rtl/periodic_task_tick_scheduler.sv =====
// Periodic task tick scheduler: a row of MAX_TASKS slot cells with a sequencer.
// A load request completes on acceptance; a tick request runs update, one search
// step per cell along the chain, then pick and decrement (held while output is full).
// One request at a time; the next is accepted while a result waits downstream.
// Synchronous active-low reset clears all task state, time, and sets policy 0,
// active_tasks 3. Depends on ptts_pkg and ptts_cell.
module periodic_task_tick_scheduler #(
  parameter int MAX_TASKS = ptts_pkg::PTTS_MAX_TASKS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] task_slot, [18:3] period, [34:19] run_time, [50:35] rel_deadline
  input  logic [55:0] in_tdata,
  // [0] opcode
  input  logic [0:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] running_task, [34:3] tick_time
  output logic [39:0] out_tdata,
  // [0] busy_res
  output logic [0:0]  out_tuser,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [3:0]  cfg_wdata
);
  import ptts_pkg::*;

  localparam int CNT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_TASKS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SRCH = 2'd1;
  localparam logic [1:0] ST_DEC  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      time_r, time_nxt;
  logic [1:0]       policy_r;
  logic [3:0]       active_r;
  logic             out_valid_r, out_valid_nxt;
  logic [39:0]      out_data_r, out_data_nxt;
  logic             out_busy_r, out_busy_nxt;

  logic       in_acc;
  logic       is_tick;
  logic       dec_go;
  cell_ctrl_t ctrl;
  search_t    best [MAX_TASKS];
  search_t    last;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign is_tick   = (in_tuser[0] == OP_TICK);
  assign last      = best[MAX_TASKS-1];
  // hold the pick until the output register is free
  assign dec_go    = (state_r == ST_DEC) && (!out_valid_r || out_tready);

  always_comb begin
    ctrl.load         = in_acc && !is_tick;
    ctrl.slot         = in_tdata[2:0];
    ctrl.period       = in_tdata[18:3];
    ctrl.run_time     = in_tdata[34:19];
    ctrl.rel_deadline = in_tdata[50:35];
    ctrl.update       = in_acc && is_tick;
    ctrl.now          = time_r;
    ctrl.dec          = dec_go && last.found;
    ctrl.dec_idx      = last.idx;
    ctrl.policy       = policy_r;
    ctrl.active       = active_r;
  end

  for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
    search_t chain_in;
    if (k == 0) begin : g_head
      assign chain_in = '0;
    end else begin : g_link
      assign chain_in = best[k-1];
    end
    ptts_cell #(.IDX(k)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .best_in  (chain_in),
      .best_out (best[k])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    time_nxt      = time_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_busy_nxt  = out_busy_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (is_tick) begin
            state_nxt = ST_SRCH;
            cnt_nxt   = '0;
          end else begin
            time_nxt = 32'd0;
          end
        end
      end
      ST_SRCH: begin
        // advance the candidate one cell per cycle
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_DEC;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_DEC: begin
        if (dec_go) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'd0, time_r, last.found ? last.idx[2:0] : 3'd0};
          out_busy_nxt  = last.found;
          time_nxt      = time_r + 32'd1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      time_r      <= '0;
      out_valid_r <= 1'b0;
      policy_r    <= POL_RM;
      active_r    <= 4'd3;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      time_r      <= time_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_POLICY: policy_r <= cfg_wdata[1:0];
          CFG_ACTIVE: active_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_busy_r <= out_busy_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_busy_r;

  a_dec_emits: assert property (@(posedge clk) disable iff (!rst_n)
    dec_go |=> out_tvalid)
    else $error("pick did not produce a result");

  a_tick_starts_search: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_tick) |=> (state_r == ST_SRCH) && (cnt_r == '0))
    else $error("tick did not start the search");

  a_load_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !is_tick) |=> (time_r == 32'd0) && (state_r == ST_IDLE))
    else $error("load did not restart time");

  a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DEC) && last.found) |->
      (({1'b0, last.idx} < 6'(MAX_TASKS)) &&
       ({1'b0, last.idx} < {2'b00, active_r})))
    else $error("picked slot outside the active range");

endmodule
